>>> rtl/core/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types and constants for the screen scaling map.
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

    localparam int SRC_COORD_W = 10;
    localparam int SRC_SIZE_W  = 11;
    localparam int SCR_SIZE_W  = 12;
    localparam int START_W     = 11;
    localparam int SPAN_W      = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int STEP_W      = $clog2(SCR_SIZE_W);

    localparam int MAX_SOURCE_DIM_DEF = 1024;
    localparam int MAX_SCREEN_DIM_DEF = 2048;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd3;

    localparam logic FUNC_BUILD  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic                   func;
        logic [SRC_COORD_W-1:0] src_x;
        logic [SRC_COORD_W-1:0] src_y;
    } req_t;

    typedef struct packed {
        logic [START_W-1:0] screen_x;
        logic [START_W-1:0] screen_y;
        logic [SPAN_W-1:0]  span_w;
        logic [SPAN_W-1:0]  span_h;
        logic               hit;
    } rsp_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [SPAN_W-1:0]  span;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/scm_table.sv
// ----------------------------------------------------------------------------
// scm_table
// One axis table: start and span per source index, one write and one
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_table #(
    parameter int AW = 10
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire scm_pkg::entry_t wdata,
    input  wire logic            re,
    input  wire logic [AW-1:0]   raddr,
    output scm_pkg::entry_t      rdata
);
    import scm_pkg::*;

    localparam int DEPTH = 1 << AW;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds when no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/scm_axis_gen.sv
// ----------------------------------------------------------------------------
// scm_axis_gen
// Fills one axis table: divides screen size by source size once, then walks
// the source cells with a remainder accumulator, one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_axis_gen #(
    parameter int AW = 10
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [scm_pkg::SRC_SIZE_W-1:0] n,
    input  wire logic [scm_pkg::SCR_SIZE_W-1:0] s,
    output logic                                wr_en,
    output logic [AW-1:0]                       wr_addr,
    output scm_pkg::entry_t                     wr_entry,
    output logic                                done
);
    import scm_pkg::*;

    localparam logic [1:0] G_IDLE = 2'd0;
    localparam logic [1:0] G_DIV  = 2'd1;
    localparam logic [1:0] G_WALK = 2'd2;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SCR_SIZE_W - 1);

    logic [1:0]            state_reg, state_next;
    logic                  done_reg, done_next;
    logic [SRC_SIZE_W-1:0] n_reg, n_next;
    logic [SCR_SIZE_W-1:0] dq_reg, dq_next;    // dividend, then quotient
    logic [SRC_SIZE_W-1:0] rem_reg, rem_next;  // remainder of s / n
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [SRC_SIZE_W-1:0] acc_reg, acc_next;
    logic [SCR_SIZE_W-1:0] pos_reg, pos_next;
    logic [SRC_SIZE_W-1:0] idx_reg, idx_next;

    logic [SCR_SIZE_W-1:0] trial;
    logic [SCR_SIZE_W-1:0] sum;
    logic [SCR_SIZE_W-1:0] n_ext;
    logic [SPAN_W-1:0]     cnt;

    assign n_ext = {1'b0, n_reg};
    assign trial = {rem_reg, dq_reg[SCR_SIZE_W-1]};
    assign sum   = {1'b0, acc_reg} + {1'b0, rem_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        acc_reg  <= acc_next;
        pos_reg  <= pos_next;
        idx_reg  <= idx_next;
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        n_next     = n_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        wr_en      = 1'b0;
        cnt        = dq_reg;
        unique case (state_reg)
            G_IDLE:
            begin
                if (start)
                begin
                    if (n == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        n_next     = n;
                        dq_next    = s;
                        rem_next   = '0;
                        step_next  = '0;
                        acc_next   = '0;
                        pos_next   = '0;
                        idx_next   = '0;
                        state_next = G_DIV;
                    end
                end
            end
            G_DIV:
            begin
                if (trial >= n_ext)
                begin
                    rem_next = SRC_SIZE_W'(trial - n_ext);
                    dq_next  = {dq_reg[SCR_SIZE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[SRC_SIZE_W-1:0];
                    dq_next  = {dq_reg[SCR_SIZE_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = G_WALK;
                end
            end
            G_WALK:
            begin
                wr_en = 1'b1;
                // acc + s = acc + q*n + r, and acc + r < 2n
                if (sum >= n_ext)
                begin
                    acc_next = SRC_SIZE_W'(sum - n_ext);
                    cnt      = dq_reg + 1'b1;
                end
                else
                begin
                    acc_next = sum[SRC_SIZE_W-1:0];
                    cnt      = dq_reg;
                end
                pos_next = pos_reg + cnt;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == n_reg - 1'b1)
                begin
                    state_next = G_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = G_IDLE;
            end
        endcase
    end

    assign wr_addr        = AW'(idx_reg);
    assign wr_entry.start = pos_reg[START_W-1:0];
    assign wr_entry.span  = cnt;
    assign done           = done_reg;

endmodule

`default_nettype wire

>>> rtl/core/screen_scaling_map_core.sv
// ----------------------------------------------------------------------------
// screen_scaling_map_core
// Source-to-screen pixel map with per-column and per-row start/span tables.
// ----------------------------------------------------------------------------
// Usage:
//   req (valid/ready) carries a func bit and a source coordinate. A build
//   word (func 0) fills the column and row tables from the size registers,
//   latched when the build is taken. A lookup word (func 1) returns the
//   screen start and span of source pixel (src_x, src_y), or all zeros with
//   hit low when out of range or before the first build.
//   rsp (valid/ready) returns exactly one word per request, in order; a build
//   answers an all-zero word.
//   Lookups: one word per cycle while rsp is not stalled; each answer passes
//   one table read register, then the output register, before rsp_valid.
//   Builds: req_ready stays low while a build runs, with 12 divide steps per
//   axis and one table entry per cycle; an empty axis skips the divide and
//   the walk; the axes are filled one after the other.
//   The size registers are written over cfg_we/cfg_index/cfg_data.
//   Reset clears the pipeline and the built flag; tables need no clearing.
//   A stalled rsp holds its word; one more lookup can sit in the read stage,
//   after which req_ready drops until rsp_ready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module screen_scaling_map_core #(
    parameter int MAX_SOURCE_DIM = scm_pkg::MAX_SOURCE_DIM_DEF,
    parameter int MAX_SCREEN_DIM = scm_pkg::MAX_SCREEN_DIM_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [scm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [scm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire scm_pkg::req_t                   req,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output scm_pkg::rsp_t                        rsp
);
    import scm_pkg::*;

    localparam int AW = $clog2(MAX_SOURCE_DIM);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_COL  = 2'd1;
    localparam logic [1:0] S_ROW  = 2'd2;

    // configuration registers
    logic [SRC_SIZE_W-1:0] src_w_reg, src_h_reg;
    logic [SCR_SIZE_W-1:0] scr_w_reg, scr_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= SRC_SIZE_W'(640);
            src_h_reg <= SRC_SIZE_W'(480);
            scr_w_reg <= SCR_SIZE_W'(640);
            scr_h_reg <= SCR_SIZE_W'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:  src_w_reg <= cfg_data[SRC_SIZE_W-1:0];
                REG_SOURCE_HEIGHT: src_h_reg <= cfg_data[SRC_SIZE_W-1:0];
                REG_SCREEN_WIDTH:  scr_w_reg <= cfg_data[SCR_SIZE_W-1:0];
                REG_SCREEN_HEIGHT: scr_h_reg <= cfg_data[SCR_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // saturated sizes
    logic [SRC_SIZE_W-1:0] w_sat, h_sat;
    logic [SCR_SIZE_W-1:0] sw_sat, sh_sat;

    assign w_sat  = (32'(src_w_reg) > MAX_SOURCE_DIM) ? SRC_SIZE_W'(MAX_SOURCE_DIM) : src_w_reg;
    assign h_sat  = (32'(src_h_reg) > MAX_SOURCE_DIM) ? SRC_SIZE_W'(MAX_SOURCE_DIM) : src_h_reg;
    assign sw_sat = (32'(scr_w_reg) > MAX_SCREEN_DIM) ? SCR_SIZE_W'(MAX_SCREEN_DIM) : scr_w_reg;
    assign sh_sat = (32'(scr_h_reg) > MAX_SCREEN_DIM) ? SCR_SIZE_W'(MAX_SCREEN_DIM) : scr_h_reg;

    // build sequencer
    logic [1:0]            seq_reg, seq_next;
    logic                  built_reg, built_next;
    logic [SRC_SIZE_W-1:0] built_w_reg, built_w_next;
    logic [SRC_SIZE_W-1:0] built_h_reg, built_h_next;
    logic [SRC_SIZE_W-1:0] lat_w_reg, lat_h_reg;
    logic [SCR_SIZE_W-1:0] lat_sh_reg;

    logic                  req_acc;
    logic                  build_acc;
    logic                  gen_start;
    logic [SRC_SIZE_W-1:0] gen_n;
    logic [SCR_SIZE_W-1:0] gen_s;
    logic                  gen_wr_en;
    logic [AW-1:0]         gen_wr_addr;
    entry_t                gen_wr_entry;
    logic                  gen_done;

    // lookup pipeline
    logic s1_valid_reg, s1_valid_next;
    logic s1_hit_reg;
    logic s1_adv;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg;
    logic lookup_hit;
    entry_t col_rd, row_rd;

    assign s1_adv    = !rsp_valid_reg || rsp_ready;
    assign req_ready = (seq_reg == S_IDLE) && (!s1_valid_reg || s1_adv);
    assign req_acc   = req_valid && req_ready;
    assign build_acc = req_acc && (req.func == FUNC_BUILD);

    assign lookup_hit = built_reg && (req.func == FUNC_LOOKUP)
                        && ({1'b0, req.src_x} < built_w_reg)
                        && ({1'b0, req.src_y} < built_h_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= S_IDLE;
            built_reg     <= 1'b0;
            built_w_reg   <= '0;
            built_h_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            built_reg     <= built_next;
            built_w_reg   <= built_w_next;
            built_h_reg   <= built_h_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (build_acc)
        begin
            lat_w_reg  <= w_sat;
            lat_h_reg  <= h_sat;
            lat_sh_reg <= sh_sat;
        end
        if (req_acc)
        begin
            s1_hit_reg <= lookup_hit;
        end
        if (s1_valid_reg && s1_adv)
        begin
            if (s1_hit_reg)
            begin
                rsp_reg.screen_x <= col_rd.start;
                rsp_reg.screen_y <= row_rd.start;
                rsp_reg.span_w   <= col_rd.span;
                rsp_reg.span_h   <= row_rd.span;
                rsp_reg.hit      <= 1'b1;
            end
            else
            begin
                rsp_reg <= '0;
            end
        end
    end

    always_comb
    begin
        seq_next     = seq_reg;
        built_next   = built_reg;
        built_w_next = built_w_reg;
        built_h_next = built_h_reg;
        gen_start    = 1'b0;
        gen_n        = w_sat;
        gen_s        = sw_sat;
        unique case (seq_reg)
            S_IDLE:
            begin
                if (build_acc)
                begin
                    gen_start = 1'b1;
                    seq_next  = S_COL;
                end
            end
            S_COL:
            begin
                gen_n = lat_h_reg;
                gen_s = lat_sh_reg;
                if (gen_done)
                begin
                    gen_start = 1'b1;
                    seq_next  = S_ROW;
                end
            end
            S_ROW:
            begin
                if (gen_done)
                begin
                    built_next   = 1'b1;
                    built_w_next = lat_w_reg;
                    built_h_next = lat_h_reg;
                    seq_next     = S_IDLE;
                end
            end
            default:
            begin
                seq_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (s1_valid_reg && s1_adv)
        begin
            rsp_valid_next = 1'b1;
            s1_valid_next  = 1'b0;
        end
        if (req_acc)
        begin
            s1_valid_next = 1'b1;
        end
    end

    scm_axis_gen #(
        .AW (AW)
    ) u_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (gen_start),
        .n        (gen_n),
        .s        (gen_s),
        .wr_en    (gen_wr_en),
        .wr_addr  (gen_wr_addr),
        .wr_entry (gen_wr_entry),
        .done     (gen_done)
    );

    scm_table #(
        .AW (AW)
    ) u_col_table (
        .clk   (clk),
        .we    (gen_wr_en && (seq_reg == S_COL)),
        .waddr (gen_wr_addr),
        .wdata (gen_wr_entry),
        .re    (req_acc),
        .raddr (AW'(req.src_x)),
        .rdata (col_rd)
    );

    scm_table #(
        .AW (AW)
    ) u_row_table (
        .clk   (clk),
        .we    (gen_wr_en && (seq_reg == S_ROW)),
        .waddr (gen_wr_addr),
        .wdata (gen_wr_entry),
        .re    (req_acc),
        .raddr (AW'(req.src_y)),
        .rdata (row_rd)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // table writes only while the sequencer is filling an axis
    a_write_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        gen_wr_en |-> (seq_reg == S_COL || seq_reg == S_ROW))
        else $error("table write outside build");

    // a hit can only come from built tables
    a_hit_built: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.hit) |-> built_reg)
        else $error("hit before tables built");

    // a stalled read stage keeps its word
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_hit_reg)))
        else $error("read stage word lost under stall");

    // no request is taken while a build runs
    a_no_req_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |-> (seq_reg == S_IDLE))
        else $error("request accepted during build");

endmodule

`default_nettype wire

>>> sim/screen_scaling_map_core_tb.sv
// ----------------------------------------------------------------------------
// screen_scaling_map_core_tb
// Drives build and lookup words into the scaling map core and checks every
// response word against a span predictor kept in a small scoreboard class.
// Size registers are changed between phases while the core is idle; the run
// covers extreme, zero and saturating sizes, random content and
// back-pressure on both channels.
// ----------------------------------------------------------------------------
module screen_scaling_map_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import scm_pkg::*;

    localparam int NUM_WORDS = 1200;
    localparam int HOLD_CYCLES = 300;

    // Column/row table predictor plus the queue of expected response words.
    class span_scoreboard;
        logic [START_W-1:0] col_start [MAX_SOURCE_DIM_DEF];
        logic [SPAN_W-1:0]  col_span  [MAX_SOURCE_DIM_DEF];
        logic [START_W-1:0] row_start [MAX_SOURCE_DIM_DEF];
        logic [SPAN_W-1:0]  row_span  [MAX_SOURCE_DIM_DEF];
        logic [SRC_SIZE_W-1:0] src_w = SRC_SIZE_W'(640);
        logic [SRC_SIZE_W-1:0] src_h = SRC_SIZE_W'(480);
        logic [SCR_SIZE_W-1:0] scr_w = SCR_SIZE_W'(640);
        logic [SCR_SIZE_W-1:0] scr_h = SCR_SIZE_W'(480);
        bit          built = 1'b0;
        int unsigned built_w = 0;
        int unsigned built_h = 0;
        rsp_t        span_q[$];
        int          errors = 0;

        function void write_register(logic [CFG_INDEX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SOURCE_WIDTH:  src_w = data[SRC_SIZE_W-1:0];
                REG_SOURCE_HEIGHT: src_h = data[SRC_SIZE_W-1:0];
                REG_SCREEN_WIDTH:  scr_w = data[SCR_SIZE_W-1:0];
                REG_SCREEN_HEIGHT: scr_h = data[SCR_SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // Remainder-accumulator walk of one axis: n source cells over s screen cells.
        function void fill_axis(bit rows, int unsigned n, int unsigned s);
            int unsigned acc = 0;
            int unsigned pos = 0;
            int unsigned cnt;
            for (int unsigned i = 0; i < n; i++)
            begin
                acc += s;
                cnt = acc / n;
                acc = acc % n;
                if (rows)
                begin
                    row_start[i] = pos[START_W-1:0];
                    row_span[i]  = cnt[SPAN_W-1:0];
                end
                else
                begin
                    col_start[i] = pos[START_W-1:0];
                    col_span[i]  = cnt[SPAN_W-1:0];
                end
                pos += cnt;
            end
        endfunction

        function void note_request(req_t w);
            rsp_t want;
            int unsigned nw, nh, sw, sh;
            want = '0;
            if (w.func == FUNC_BUILD)
            begin
                nw = (src_w > MAX_SOURCE_DIM_DEF) ? MAX_SOURCE_DIM_DEF : src_w;
                nh = (src_h > MAX_SOURCE_DIM_DEF) ? MAX_SOURCE_DIM_DEF : src_h;
                sw = (scr_w > MAX_SCREEN_DIM_DEF) ? MAX_SCREEN_DIM_DEF : scr_w;
                sh = (scr_h > MAX_SCREEN_DIM_DEF) ? MAX_SCREEN_DIM_DEF : scr_h;
                fill_axis(1'b0, nw, sw);
                fill_axis(1'b1, nh, sh);
                built_w = nw;
                built_h = nh;
                built = 1'b1;
            end
            else if (built && w.src_x < built_w && w.src_y < built_h)
            begin
                want.screen_x = col_start[w.src_x];
                want.screen_y = row_start[w.src_y];
                want.span_w   = col_span[w.src_x];
                want.span_h   = row_span[w.src_y];
                want.hit      = 1'b1;
            end
            span_q.push_back(want);
        endfunction

        function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
            if (got_v !== want_v)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (span_q.size() == 0)
            begin
                $display("%0t: unexpected response word, expected none, got %p", $time, got);
                errors++;
                return;
            end
            want = span_q.pop_front();
            compare_field("screen_x", 16'(want.screen_x), 16'(got.screen_x));
            compare_field("screen_y", 16'(want.screen_y), 16'(got.screen_y));
            compare_field("span_w", 16'(want.span_w), 16'(got.span_w));
            compare_field("span_h", 16'(want.span_h), 16'(got.span_h));
            compare_field("hit", 16'(want.hit), 16'(got.hit));
        endfunction

        function int pending();
            return span_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   req_valid;
    logic                   req_ready;
    req_t                   req;
    logic                   rsp_valid;
    logic                   rsp_ready;
    rsp_t                   rsp;

    span_scoreboard board = new();
    bit             hold_request = 1'b0;
    int             sent_words = 0;

    screen_scaling_map_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        req_valid = 1'b0;
        req       = '0;
        rsp_ready = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("FAIL screen_scaling_map_core");
        $finish;
    end

    // Receiver: random stall segments, plus one long hold-off on request.
    initial
    begin
        int hold_left = 0;
        int seg_left = 0;
        int mode = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                board.check_response(rsp);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                case (mode)
                    0: rsp_ready <= 1'b1;
                    1: rsp_ready <= 1'($urandom_range(0, 1));
                    default: rsp_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic req_t make_req(logic f, int x, int y);
        req_t w;
        w.func  = f;
        w.src_x = SRC_COORD_W'(x);
        w.src_y = SRC_COORD_W'(y);
        return w;
    endfunction

    // Mostly in-range coordinates of the last build, some just past the edge,
    // the rest anywhere.
    function automatic req_t random_lookup();
        logic [SRC_COORD_W-1:0] x;
        logic [SRC_COORD_W-1:0] y;
        x = SRC_COORD_W'($urandom);
        y = SRC_COORD_W'($urandom);
        if (board.built && $urandom_range(0, 4) != 0)
        begin
            if (board.built_w > 0)
                x = SRC_COORD_W'($urandom_range(0, board.built_w - 1));
            if (board.built_h > 0)
                y = SRC_COORD_W'($urandom_range(0, board.built_h - 1));
            if ($urandom_range(0, 9) == 0)
                x = SRC_COORD_W'(board.built_w);
            if ($urandom_range(0, 9) == 0)
                y = SRC_COORD_W'(board.built_h);
        end
        return make_req(FUNC_LOOKUP, int'(x), int'(y));
    endfunction

    function automatic int pick_source();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        else if (r < 12)
            return MAX_SOURCE_DIM_DEF;
        else if (r < 16)
            return $urandom_range(MAX_SOURCE_DIM_DEF + 1, 2047);
        else if (r < 19)
            return 2048 + int'($urandom_range(1, 48));   // bit above the register
        else
            return $urandom_range(1, 48);
    endfunction

    function automatic int pick_screen();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 0;
        else if (r < 12)
            return MAX_SCREEN_DIM_DEF;
        else if (r < 16)
            return $urandom_range(MAX_SCREEN_DIM_DEF + 1, 4095);
        else if (r < 30)
            return $urandom_range(0, MAX_SCREEN_DIM_DEF);
        else
            return $urandom_range(0, 200);
    endfunction

    // Leaves req_valid high on return; the caller lowers it only before a gap.
    task automatic send_word(input req_t w);
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        board.note_request(w);
        sent_words++;
    endtask

    task automatic idle_sender(input int cycles);
        req_valid <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // Every response back and no build still walking the tables.
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (board.pending() > 0)
            @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        @(posedge clk);
        board.write_register(idx, CFG_DATA_W'(data));
    endtask

    task automatic set_sizes(input int sw, input int sh, input int scw, input int sch);
        wait_idle();
        write_reg(REG_SOURCE_WIDTH, sw);
        write_reg(REG_SOURCE_HEIGHT, sh);
        write_reg(REG_SCREEN_WIDTH, scw);
        write_reg(REG_SCREEN_HEIGHT, sch);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int phase = 0;
        int n_left;
        int burst;
        int gap;

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lookups before the first build miss
        send_word(make_req(FUNC_LOOKUP, 0, 0));
        send_word(make_req(FUNC_LOOKUP, 1023, 1023));
        // reset sizes
        send_word(make_req(FUNC_BUILD, 1023, 1023));
        send_word(make_req(FUNC_LOOKUP, 0, 0));
        send_word(make_req(FUNC_LOOKUP, 639, 479));
        send_word(make_req(FUNC_LOOKUP, 640, 0));
        send_word(make_req(FUNC_LOOKUP, 0, 480));
        // largest legal sizes
        set_sizes(MAX_SOURCE_DIM_DEF, MAX_SOURCE_DIM_DEF, MAX_SCREEN_DIM_DEF, MAX_SCREEN_DIM_DEF);
        send_word(make_req(FUNC_BUILD, 0, 0));
        send_word(make_req(FUNC_LOOKUP, 1023, 1023));
        send_word(make_req(FUNC_LOOKUP, 0, 0));
        send_word(make_req(FUNC_LOOKUP, 341, 682));
        // register change without a build keeps the latched sizes
        wait_idle();
        write_reg(REG_SOURCE_WIDTH, 1);
        cfg_we <= 1'b0;
        send_word(make_req(FUNC_LOOKUP, 1023, 0));
        // oversized sizes saturate
        set_sizes('h7FF, 'h7FF, 'hFFF, 'hFFF);
        send_word(make_req(FUNC_BUILD, 0, 0));
        send_word(make_req(FUNC_LOOKUP, 1023, 1023));
        send_word(make_req(FUNC_LOOKUP, 0, 1));
        // zero source width, zero screen height
        set_sizes(0, 3, 7, 0);
        send_word(make_req(FUNC_BUILD, 0, 0));
        send_word(make_req(FUNC_LOOKUP, 0, 0));
        send_word(make_req(FUNC_LOOKUP, 0, 1));
        // zero source height
        set_sizes(3, 0, 9, 9);
        send_word(make_req(FUNC_BUILD, 0, 0));
        send_word(make_req(FUNC_LOOKUP, 2, 0));
        // one source column over the whole screen, rows stretched
        set_sizes(1, 5, MAX_SCREEN_DIM_DEF, 11);
        send_word(make_req(FUNC_BUILD, 0, 0));
        send_word(make_req(FUNC_LOOKUP, 0, 4));
        send_word(make_req(FUNC_LOOKUP, 1, 0));
        send_word(make_req(FUNC_LOOKUP, 0, 2));

        while (sent_words < NUM_WORDS)
        begin
            set_sizes(pick_source(), pick_source(), pick_screen(), pick_screen());
            if ($urandom_range(0, 9) != 0)
                send_word(make_req(FUNC_BUILD, $urandom, $urandom));
            if (phase == 2)
            begin
                // long receiver hold-off while words keep coming
                hold_request = 1'b1;
                repeat (80)
                    send_word(random_lookup());
            end
            n_left = $urandom_range(30, 120);
            while (n_left > 0)
            begin
                burst = $urandom_range(1, 30);
                while (burst > 0 && n_left > 0)
                begin
                    if ($urandom_range(0, 49) == 0)
                        send_word(make_req(FUNC_BUILD, $urandom, $urandom));
                    else
                        send_word(random_lookup());
                    burst--;
                    n_left--;
                end
                gap = $urandom_range(0, 8);
                if (gap > 0)
                    idle_sender(gap);
            end
            phase++;
        end

        req_valid <= 1'b0;
        while (board.pending() > 0)
            @(posedge clk);
        repeat (16)
            @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("PASS screen_scaling_map_core");
        else
            $display("FAIL screen_scaling_map_core");
        $finish;
    end

endmodule
